// ----- src/cfwr_pkg.sv -----
package cfwr_pkg;

  // Field widths fixed by the interface
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned FILL_W = 7;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STAT_W = 2;

  // Default ring depth and capacity register reset value
  localparam int unsigned DEPTH_DEF = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Configuration register select (paddr[2])
  localparam logic ADDR_CAPACITY = 1'b0;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ENQ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DEQ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REV  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic                     is_empty;
    logic                     is_full;
    logic [FILL_W-1:0]        fill_count;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;
    logic emit;
  } ctl_cmd_t;

endpackage

// ----- src/cfwr_regs.sv -----
module cfwr_regs
  import cfwr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [CAP_W-1:0] capacity
);

  logic [CAP_W-1:0] capacity_r;
  logic             wr_hit;

  // Decode a completed write to the capacity register
  assign wr_hit = psel && penable && pwrite && (paddr[2] == ADDR_CAPACITY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (wr_hit) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // Read back; unused addresses read as zero
  always_comb begin
    if (paddr[2] == ADDR_CAPACITY) begin
      prdata = {{(32-CAP_W){1'b0}}, capacity_r};
    end else begin
      prdata = '0;
    end
  end

  assign pready   = 1'b1;
  assign capacity = capacity_r;

endmodule

// ----- src/cfwr_ctrl.sv -----
module cfwr_ctrl
  import cfwr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Advance: IDLE executes the taken item, then RESP presents the result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cmd.exec  = start && (state_r == ST_IDLE);
  assign cmd.emit  = (state_r == ST_RESP);
  assign out_valid = cmd.emit;

endmodule

// ----- src/cfwr_dp.sv -----
module cfwr_dp
  import cfwr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_cmd_t         cmd,
  input  in_t              in_payload,
  input  logic [CAP_W-1:0] capacity,
  output out_t             out_payload
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > CAP_W) ? CW : CAP_W;

  // Word store
  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  // Queue state
  logic [IW-1:0] front_r, front_nxt;
  logic [IW-1:0] rear_r, rear_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;

  // Result registers
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [CW-1:0]     res_count_r;
  logic              res_full_r;
  logic              rd_valid_r;

  logic          wr_en, rd_en;
  logic [KW-1:0] cap_k;
  logic          is_empty_now, is_full_now;

  function automatic logic [IW-1:0] ring_up(input logic [IW-1:0] i);
    ring_up = (i == IW'(DEPTH - 1)) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] ring_down(input logic [IW-1:0] i);
    ring_down = (i == '0) ? IW'(DEPTH - 1) : i - IW'(1);
  endfunction

  // Saturate capacity to the ring depth
  assign cap_k = (KW'(capacity) > KW'(DEPTH)) ? KW'(DEPTH) : KW'(capacity);
  assign is_empty_now = (count_r == '0);
  assign is_full_now  = (KW'(count_r) >= cap_k);

  // Work out the next queue state for the current action
  always_comb begin
    front_nxt      = front_r;
    rear_nxt       = rear_r;
    count_nxt      = count_r;
    rev_nxt        = rev_r;
    res_status_nxt = STAT_DONE;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    case (in_payload.action)
      ACT_ENQ: begin
        if (is_full_now) begin
          res_status_nxt = STAT_FULL;
        end else begin
          wr_en     = 1'b1;
          rear_nxt  = rev_r ? ring_down(rear_r) : ring_up(rear_r);
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_DEQ: begin
        if (is_empty_now) begin
          res_status_nxt = STAT_EMPTY;
        end else begin
          rd_en     = 1'b1;
          front_nxt = rev_r ? ring_down(front_r) : ring_up(front_r);
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_PEEK: begin
        if (is_empty_now) begin
          res_status_nxt = STAT_EMPTY;
        end else begin
          rd_en = 1'b1;
        end
      end
      ACT_REV: begin
        // Front moves to the last word, rear to the slot behind the front
        if (!is_empty_now) begin
          front_nxt = rev_r ? ring_up(rear_r) : ring_down(rear_r);
          rear_nxt  = rev_r ? ring_up(front_r) : ring_down(front_r);
        end
        rev_nxt = !rev_r;
      end
      default: begin
        res_status_nxt = STAT_DONE;
      end
    endcase
  end

  // Update pointers, count and direction on an executed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  // Capture the result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_count_r  <= count_nxt;
      res_full_r   <= (KW'(count_nxt) >= cap_k);
      rd_valid_r   <= rd_en;
    end
  end

  // Store write
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem_r[rear_r] <= in_payload.value;
    end
  end

  // Registered store read at the front slot
  always_ff @(posedge clk) begin
    if (cmd.exec && rd_en) begin
      rdata_r <= mem_r[front_r];
    end
  end

  assign out_payload.read_value = rd_valid_r ? $signed(rdata_r) : '0;
  assign out_payload.status     = res_status_r;
  assign out_payload.is_empty   = (res_count_r == '0);
  assign out_payload.is_full    = res_full_r;
  assign out_payload.fill_count = FILL_W'(res_count_r);

endmodule

// ----- src/circular_fifo_with_reverse.sv -----
// The result beat is strobed on out_valid in the cycle after start is taken.
// A new item is not taken until the result beat is out, since the controller holds busy for it.
// Reset clears pointers, fill count and direction and sets capacity to 64;
// the word store is not cleared. The receiver cannot stall: each result beat
// is shown for exactly one cycle.
module circular_fifo_with_reverse
  import cfwr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_payload,
  output logic        out_valid,
  output out_t        out_payload,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctl_cmd_t         cmd;
  logic [CAP_W-1:0] capacity;

  cfwr_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  cfwr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  cfwr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_payload  (in_payload),
    .capacity    (capacity),
    .out_payload (out_payload)
  );

  // Every accepted item gives its result beat on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("result beat missing after accept");

  // A result beat never repeats
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat repeated");

  // Rejected actions read nothing
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_payload.status != STAT_DONE)) |-> (out_payload.read_value == '0))
    else $error("rejected action returned data");

  // Empty flag agrees with the fill count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.is_empty == (out_payload.fill_count == '0)))
    else $error("empty flag disagrees with fill count");

endmodule

// ----- dv/fifo_reverse_checker.sv -----
`timescale 1ns / 100ps

module fifo_reverse_checker
  import cfwr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_payload,
  input  logic        out_valid,
  input  out_t        out_payload,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned outstanding,
  output int unsigned fail_count
);

  // Shadow copy of the queue state and the capacity register
  logic signed [WORD_W-1:0] ring_words [DEPTH_DEF];
  int unsigned              head_slot;
  int unsigned              tail_slot;
  int unsigned              held_words;
  logic                     walk_down;
  logic [CAP_W-1:0]         cap_reg;

  out_t expected_beats[$];

  // One slot along the ring, upward or downward
  function automatic int unsigned step_slot(int unsigned i, logic downward);
    if (downward) begin
      return (i == 0) ? DEPTH_DEF - 1 : i - 1;
    end
    return (i == DEPTH_DEF - 1) ? 0 : i + 1;
  endfunction

  // Apply one action to the shadow queue and return the beat it should produce
  function automatic out_t predict_fifo_step(in_t item);
    out_t        r;
    int unsigned lim;
    int unsigned last_slot;
    int unsigned pre_front;
    r = '0;
    lim = (cap_reg > DEPTH_DEF) ? DEPTH_DEF : cap_reg;
    r.status = STAT_DONE;
    case (item.action)
      ACT_ENQ: begin
        if (held_words >= lim) begin
          r.status = STAT_FULL;
        end else begin
          ring_words[tail_slot] = item.value;
          tail_slot = step_slot(tail_slot, walk_down);
          held_words++;
        end
      end
      ACT_DEQ: begin
        if (held_words == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.read_value = ring_words[head_slot];
          head_slot = step_slot(head_slot, walk_down);
          held_words--;
        end
      end
      ACT_PEEK: begin
        if (held_words == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.read_value = ring_words[head_slot];
        end
      end
      default: begin
        // Reverse: front jumps to the newest word and the walk flips
        last_slot = step_slot(tail_slot, !walk_down);
        pre_front = step_slot(head_slot, !walk_down);
        if (held_words != 0) begin
          head_slot = last_slot;
          tail_slot = pre_front;
        end
        walk_down = !walk_down;
      end
    endcase
    r.is_empty   = (held_words == 0);
    r.is_full    = (held_words >= lim);
    r.fill_count = FILL_W'(held_words);
    return r;
  endfunction

  function automatic int unsigned check_field(string name, logic [31:0] exp_v,
                                              logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_t        exp_beat;
    int unsigned errs;
    int unsigned pushed;
    int unsigned popped;
    errs = 0;
    pushed = 0;
    popped = 0;
    if (!rst_n) begin
      head_slot = 0;
      tail_slot = 0;
      held_words = 0;
      walk_down = 1'b0;
      cap_reg = CAP_RESET;
      expected_beats.delete();
      outstanding <= 0;
      fail_count <= 0;
    end else begin
      // Compare the result beat against the oldest expectation
      if (out_valid) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected: %0h", $time, out_payload);
          errs++;
        end else begin
          exp_beat = expected_beats.pop_front();
          popped = 1;
          errs += check_field("read_value", exp_beat.read_value, out_payload.read_value);
          errs += check_field("status", 32'(exp_beat.status), 32'(out_payload.status));
          errs += check_field("is_empty", 32'(exp_beat.is_empty), 32'(out_payload.is_empty));
          errs += check_field("is_full", 32'(exp_beat.is_full), 32'(out_payload.is_full));
          errs += check_field("fill_count", 32'(exp_beat.fill_count),
                              32'(out_payload.fill_count));
        end
      end

      // Predict the beat for an accepted command
      if (start && !busy) begin
        expected_beats.push_back(predict_fifo_step(in_payload));
        pushed = 1;
      end

      // Track register writes and check read data
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == ADDR_CAPACITY) begin
            cap_reg = pwdata[CAP_W-1:0];
          end
        end else if (paddr[2] == ADDR_CAPACITY) begin
          errs += check_field("capacity readback", {{(32-CAP_W){1'b0}}, cap_reg}, prdata);
        end
      end

      outstanding <= outstanding + pushed - popped;
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import cfwr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned STALL_LIMIT  = 2000;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_payload;
  logic        out_valid;
  out_t        out_payload;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned stall_cycles;
  int unsigned sent;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  circular_fifo_with_reverse i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_payload(out_payload),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  fifo_reverse_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_payload(out_payload),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .outstanding(outstanding),
    .fail_count (fail_count)
  );

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Present one command beat and hold it until taken
  task automatic send_cmd(logic [ACT_W-1:0] act, logic signed [WORD_W-1:0] val);
    @(negedge clk);
    start <= 1'b1;
    in_payload <= '{action: act, value: val};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // Drop start with junk on the payload; n sets how long the gap lasts
  task automatic idle_cycles(int unsigned n);
    in_t junk;
    repeat (n) begin
      junk.action = ACT_W'($urandom);
      junk.value = $urandom;
      @(negedge clk);
      start <= 1'b0;
      in_payload <= junk;
    end
  endtask

  // Hold off until every result beat has come back
  task automatic wait_drained();
    idle_cycles(1);
    do @(posedge clk); while (outstanding != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write capacity with random junk in the unused upper bits
  task automatic set_capacity(logic [CAP_W-1:0] c);
    logic [31:0] data;
    data = $urandom;
    data[CAP_W-1:0] = c;
    apb_access(1'b1, {ADDR_CAPACITY, 2'b00}, data);
    apb_access(1'b0, {ADDR_CAPACITY, 2'b00}, '0);
  endtask

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(traffic_mode_e mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return ACT_REV;
    if (roll < 20) return ACT_PEEK;
    case (mode)
      MODE_FILL:  return (roll < 85) ? ACT_ENQ : ACT_DEQ;
      MODE_DRAIN: return (roll < 35) ? ACT_ENQ : ACT_DEQ;
      default:    return (roll < 60) ? ACT_ENQ : ACT_DEQ;
    endcase
  endfunction

  initial begin
    traffic_mode_e    mode;
    int unsigned      run_left;
    int unsigned      per_phase;
    logic [CAP_W-1:0] cap_plan [PHASES];

    rst_n = 1'b0;
    start = 1'b0;
    in_payload = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: empty queue, extremes, reversal, capacity corners
    send_cmd(ACT_PEEK, 32'sd5);
    send_cmd(ACT_DEQ, 32'sd5);
    send_cmd(ACT_REV, 32'sd5);
    send_cmd(ACT_ENQ, 32'sh7FFF_FFFF);
    send_cmd(ACT_ENQ, 32'sh8000_0000);
    send_cmd(ACT_ENQ, 32'sd0);
    send_cmd(ACT_ENQ, -32'sd1);
    send_cmd(ACT_PEEK, 32'sd0);
    send_cmd(ACT_REV, 32'sd0);
    send_cmd(ACT_PEEK, 32'sd0);
    send_cmd(ACT_DEQ, 32'sd0);
    send_cmd(ACT_DEQ, 32'sd0);
    send_cmd(ACT_REV, 32'sd0);
    send_cmd(ACT_DEQ, 32'sd0);
    send_cmd(ACT_DEQ, 32'sd0);
    send_cmd(ACT_DEQ, 32'sd0);
    wait_drained();
    set_capacity(7'd1);
    send_cmd(ACT_ENQ, 32'sd1);
    send_cmd(ACT_ENQ, 32'sd2);
    send_cmd(ACT_PEEK, 32'sd0);
    send_cmd(ACT_DEQ, 32'sd0);
    wait_drained();
    set_capacity(7'd0);
    send_cmd(ACT_ENQ, 32'sd3);
    send_cmd(ACT_REV, 32'sd0);
    send_cmd(ACT_DEQ, 32'sd0);
    wait_drained();
    set_capacity(7'd64);
    send_cmd(ACT_ENQ, 32'sd10);
    send_cmd(ACT_ENQ, 32'sd11);
    send_cmd(ACT_ENQ, 32'sd12);
    wait_drained();
    // Lower capacity under the fill count, then poke the unused address
    set_capacity(7'd2);
    apb_access(1'b1, {~ADDR_CAPACITY, 2'b00}, $urandom);
    send_cmd(ACT_ENQ, 32'sd13);
    send_cmd(ACT_DEQ, 32'sd0);
    send_cmd(ACT_ENQ, 32'sd14);

    // Random phases, each under its own capacity; fill carries across phases
    cap_plan = '{7'd127, 7'd1, 7'd64, 7'd0, 7'd2, 7'($urandom_range(3, 63)),
                 7'($urandom_range(65, 126)), 7'd5, 7'd64, 7'($urandom_range(1, 64))};
    per_phase = RANDOM_ITEMS / PHASES;
    sent = 0;
    mode = MODE_FILL;
    run_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      set_capacity(cap_plan[p]);
      if ($urandom_range(0, 2) == 0) begin
        apb_access(1'b1, {~ADDR_CAPACITY, 2'b00}, $urandom);
      end
      for (int k = 0; k < per_phase; k++) begin
        if (run_left == 0) begin
          mode = traffic_mode_e'($urandom_range(0, 2));
          run_left = $urandom_range(20, 40);
        end
        run_left--;
        // Sender gaps, but none near the end of the run
        if (sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 7) == 0) begin
          idle_cycles($urandom_range(1, 13));
        end
        if (p == 2 && k == per_phase / 2) begin
          wait_drained();
        end
        send_cmd(pick_action(mode), pick_word());
      end
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/cfwr_pkg.sv
src/cfwr_regs.sv
src/cfwr_ctrl.sv
src/cfwr_dp.sv
src/circular_fifo_with_reverse.sv
dv/fifo_reverse_checker.sv
dv/tb.sv
